FILE: src/kscl_pkg.sv
// Shared types and constants for the keypad scanner with code lock.
package kscl_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 16;

  localparam logic [CfgIndexWidth-1:0] CFG_SETTLE_TICKS   = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_DEBOUNCE_TICKS = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_CODE_KEY_0     = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_CODE_KEY_1     = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CFG_CODE_KEY_2     = 3'd4;
  localparam logic [CfgIndexWidth-1:0] CFG_CODE_KEY_3     = 3'd5;

  localparam logic [1:0] IND_OFF   = 2'd0;
  localparam logic [1:0] IND_RED   = 2'd1;
  localparam logic [1:0] IND_GREEN = 2'd2;

  localparam logic [1:0] MOTION_NONE   = 2'd0;
  localparam logic [1:0] MOTION_UNLOCK = 2'd1;
  localparam logic [1:0] MOTION_LOCK   = 2'd2;

  typedef struct packed {
    logic [3:0] col_sense;
  } sample_t;

  typedef struct packed {
    logic [3:0] row_drive;
    logic       key_valid;
    logic [3:0] key_code;
    logic       unlocked;
    logic [1:0] led_state;
    logic [1:0] motion_request;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] code;
  } key_event_t;

endpackage

FILE: src/kscl_stream_if.sv
// Valid/ready channel interface carrying one payload per transaction.
interface kscl_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/kscl_scan.sv
// Row scanner with settle, debounce and release detection for a 4x4 keypad.
module kscl_scan (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [3:0]            col_sense,
  input  logic [15:0]           settle_ticks,
  input  logic [15:0]           debounce_ticks,
  output logic [3:0]            row_drive,
  output kscl_pkg::key_event_t  key_event
);

  localparam logic [1:0] PH_SETTLE   = 2'd0;
  localparam logic [1:0] PH_DEBOUNCE = 2'd1;
  localparam logic [1:0] PH_RELEASE  = 2'd2;

  logic [1:0]  scan_phase, scan_phase_next;
  logic [1:0]  scan_row, scan_row_next;
  logic [1:0]  held_column, held_column_next;
  logic [15:0] wait_timer, wait_timer_next;
  logic [3:0]  low_cols;
  logic [1:0]  first_low;

  assign row_drive = ~(4'b0001 << scan_row);
  assign low_cols  = ~col_sense;

  always_comb begin
    if (low_cols[0]) begin
      first_low = 2'd0;
    end else if (low_cols[1]) begin
      first_low = 2'd1;
    end else if (low_cols[2]) begin
      first_low = 2'd2;
    end else begin
      first_low = 2'd3;
    end
  end

  always_comb begin
    scan_phase_next  = scan_phase;
    scan_row_next    = scan_row;
    held_column_next = held_column;
    wait_timer_next  = wait_timer;
    key_event        = '0;
    case (scan_phase)
      PH_SETTLE: begin
        if (wait_timer < settle_ticks) begin
          wait_timer_next = wait_timer + 16'd1;
        end else begin
          wait_timer_next = '0;
          if (low_cols != 4'd0) begin
            held_column_next = first_low;
            scan_phase_next  = PH_DEBOUNCE;
          end else begin
            scan_row_next = scan_row + 2'd1;
          end
        end
      end
      PH_DEBOUNCE: begin
        if (wait_timer < debounce_ticks) begin
          wait_timer_next = wait_timer + 16'd1;
        end else begin
          scan_phase_next = PH_RELEASE;
        end
      end
      PH_RELEASE: begin
        if (col_sense[held_column]) begin
          key_event.valid = 1'b1;
          key_event.code  = {scan_row, held_column};
          scan_row_next   = 2'd0;
          scan_phase_next = PH_SETTLE;
          wait_timer_next = '0;
        end
      end
      default: begin
        scan_phase_next = PH_SETTLE;
        wait_timer_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase  <= PH_SETTLE;
      scan_row    <= 2'd0;
      held_column <= 2'd0;
      wait_timer  <= '0;
    end else if (step) begin
      scan_phase  <= scan_phase_next;
      scan_row    <= scan_row_next;
      held_column <= held_column_next;
      wait_timer  <= wait_timer_next;
    end
  end

endmodule

FILE: src/keypad_scan_code_lock.sv
// Top level: keypad scanner, four-key code check and lock state with result buffering.
//
// Each accepted transaction on sample is one scan tick and yields exactly one
// transaction on result, in order. The scan step, the key check and the lock
// update are done in the cycle a sample is accepted, and the result is held in
// an output register backed by one skid register, so a sample can be accepted
// every cycle as long as result is drained; sample.ready drops only while both
// registers hold untaken results. Configuration writes are taken at any edge
// with cfg_we high and should be made while no results are outstanding.
module keypad_scan_code_lock (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_we,
  input  logic [kscl_pkg::CfgIndexWidth-1:0]       cfg_index,
  input  logic [kscl_pkg::CfgDataWidth-1:0]        cfg_data,
  kscl_stream_if.sink                              sample,
  kscl_stream_if.source                            result
);

  logic [15:0] settle_ticks;
  logic [15:0] debounce_ticks;
  logic [3:0]  code_key [4];

  logic [3:0]  entered_keys [3];
  logic [1:0]  entered_count;
  logic        lock_open, lock_open_next;
  logic [1:0]  indicator, indicator_next;
  logic [1:0]  motion;
  logic        match;

  logic        accept;
  logic [3:0]  row_drive;
  kscl_pkg::key_event_t key_event;
  kscl_pkg::result_t    new_result;
  kscl_pkg::result_t    out_data;
  kscl_pkg::result_t    skid_data;
  logic        out_valid;
  logic        skid_valid;
  logic        out_fire;

  assign sample.ready = !skid_valid;
  assign accept       = sample.valid && sample.ready;
  assign out_fire     = out_valid && result.ready;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ticks   <= 16'd1;
      debounce_ticks <= 16'd20;
      code_key[0]    <= 4'd1;
      code_key[1]    <= 4'd2;
      code_key[2]    <= 4'd3;
      code_key[3]    <= 4'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        kscl_pkg::CFG_SETTLE_TICKS:   settle_ticks   <= cfg_data;
        kscl_pkg::CFG_DEBOUNCE_TICKS: debounce_ticks <= cfg_data;
        kscl_pkg::CFG_CODE_KEY_0:     code_key[0]    <= cfg_data[3:0];
        kscl_pkg::CFG_CODE_KEY_1:     code_key[1]    <= cfg_data[3:0];
        kscl_pkg::CFG_CODE_KEY_2:     code_key[2]    <= cfg_data[3:0];
        kscl_pkg::CFG_CODE_KEY_3:     code_key[3]    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  kscl_scan u_scan (
    .clk            (clk),
    .rst            (rst),
    .step           (accept),
    .col_sense      (sample.data.col_sense),
    .settle_ticks   (settle_ticks),
    .debounce_ticks (debounce_ticks),
    .row_drive      (row_drive),
    .key_event      (key_event)
  );

  // The fourth key is compared as it arrives and is never stored.
  assign match = (entered_keys[0] == code_key[0]) && (entered_keys[1] == code_key[1]) &&
                 (entered_keys[2] == code_key[2]) && (key_event.code == code_key[3]);

  always_comb begin
    lock_open_next = lock_open;
    indicator_next = indicator;
    motion         = kscl_pkg::MOTION_NONE;
    if (key_event.valid && entered_count == 2'd3) begin
      if (match && !lock_open) begin
        lock_open_next = 1'b1;
        indicator_next = kscl_pkg::IND_GREEN;
        motion         = kscl_pkg::MOTION_UNLOCK;
      end else if (!match && lock_open) begin
        lock_open_next = 1'b0;
        indicator_next = kscl_pkg::IND_RED;
        motion         = kscl_pkg::MOTION_LOCK;
      end
    end
  end

  always_comb begin
    new_result.row_drive      = row_drive;
    new_result.key_valid      = key_event.valid;
    new_result.key_code       = key_event.code;
    new_result.unlocked       = lock_open_next;
    new_result.led_state      = indicator_next;
    new_result.motion_request = motion;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entered_count <= 2'd0;
      lock_open     <= 1'b0;
      indicator     <= kscl_pkg::IND_OFF;
    end else if (accept) begin
      lock_open <= lock_open_next;
      indicator <= indicator_next;
      if (key_event.valid) begin
        entered_count <= entered_count + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && key_event.valid && entered_count != 2'd3) begin
      entered_keys[entered_count] <= key_event.code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_fire || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= accept;
      end else begin
        out_valid  <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (accept) begin
          skid_data <= new_result;
        end
      end else if (accept) begin
        out_data <= new_result;
      end
    end else if (accept) begin
      skid_data <= new_result;
    end
  end

  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("Skid register holds a result while the output register is empty.");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.motion_request != kscl_pkg::MOTION_NONE) |-> out_data.key_valid)
    else $error("Motion request reported without a key transaction.");

  assert property (@(posedge clk) disable iff (rst) lock_open |-> indicator == kscl_pkg::IND_GREEN)
    else $error("Lock is open but the indicator is not green.");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.motion_request == kscl_pkg::MOTION_UNLOCK) |-> out_data.unlocked)
    else $error("Unlock motion reported while the lock state is locked.");

endmodule
